[rtl/core/eslp_pkg.sv]
// ---------------------------------------------------------------------------
// eslp_pkg
// shared types, codes and character tables of the event stream line parser
// ---------------------------------------------------------------------------
package eslp_pkg;

	localparam int TYPE_MAX_DEF = 16;
	localparam int ID_MAX_DEF   = 16;
	localparam int QDEPTH       = 4;

	// input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	// result kinds
	localparam logic [2:0] K_DATA    = 3'd0;
	localparam logic [2:0] K_TYPE    = 3'd1;
	localparam logic [2:0] K_ID      = 3'd2;
	localparam logic [2:0] K_END     = 3'd3;
	localparam logic [2:0] K_DISCARD = 3'd4;

	// internal operation codes between front and back
	localparam logic [1:0] UOP_CONTENT  = 2'd0;
	localparam logic [1:0] UOP_LINE_END = 2'd1;
	localparam logic [1:0] UOP_EOS      = 2'd2;

	// one-hot field candidates
	localparam logic [3:0] F_EVENT = 4'b0001;
	localparam logic [3:0] F_DATA  = 4'b0010;
	localparam logic [3:0] F_ID    = 4'b0100;
	localparam logic [3:0] F_RETRY = 4'b1000;
	localparam logic [3:0] F_ALL   = 4'b1111;

	localparam logic [7:0] CH_BOM0  = 8'hEF;
	localparam logic [7:0] CH_BOM1  = 8'hBB;
	localparam logic [7:0] CH_BOM2  = 8'hBF;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam int         MSG_LEN  = 7;

	typedef struct packed {
		logic       op;
		logic [7:0] byte_in;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] byte_out;
		logic       overflow;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] code;
		logic [7:0] data;
		logic       last;
	} uop_t;

	function automatic logic [7:0] msg_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = "m";
			3'd1: c = "e";
			3'd2: c = "s";
			3'd3: c = "s";
			3'd4: c = "a";
			3'd5: c = "g";
			3'd6: c = "e";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] fld_len(input logic [1:0] k);
		logic [2:0] n;
		unique case (k)
			2'd0: n = 3'd5;
			2'd1: n = 3'd4;
			2'd2: n = 3'd2;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] fld_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = CH_NUL;
		unique case (k)
			2'd0: unique case (i)
				3'd0: c = "e";
				3'd1: c = "v";
				3'd2: c = "e";
				3'd3: c = "n";
				3'd4: c = "t";
				default: c = CH_NUL;
			endcase
			2'd1: unique case (i)
				3'd0: c = "d";
				3'd1: c = "a";
				3'd2: c = "t";
				3'd3: c = "a";
				default: c = CH_NUL;
			endcase
			2'd2: unique case (i)
				3'd0: c = "i";
				3'd1: c = "d";
				default: c = CH_NUL;
			endcase
			default: unique case (i)
				3'd0: c = "r";
				3'd1: c = "e";
				3'd2: c = "t";
				3'd3: c = "r";
				3'd4: c = "y";
				default: c = CH_NUL;
			endcase
		endcase
		return c;
	endfunction

	// drop candidates that no longer match after one more name byte
	function automatic logic [3:0] name_step(input logic [3:0] m, input logic [2:0] cnt,
			input logic [7:0] c);
		logic [3:0] r;
		r = m;
		for (int k = 0; k < 4; k++) begin
			if (m[k] && ((cnt >= fld_len(2'(k))) || (fld_char(2'(k), cnt) != c)))
				r[k] = 1'b0;
		end
		return r;
	endfunction

	// keep only the candidate whose length equals the name length
	function automatic logic [3:0] name_resolve(input logic [3:0] m, input logic [2:0] cnt);
		logic [3:0] r;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			if (m[k] && (fld_len(2'(k)) == cnt))
				r = 4'(1 << k);
		end
		return r;
	endfunction

endpackage

[rtl/core/eslp_front.sv]
// ---------------------------------------------------------------------------
// eslp_front
// byte-order-mark and carriage-return handling, expands items into operations
// ---------------------------------------------------------------------------
module eslp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  eslp_pkg::item_t item,
	output logic            uop_valid,
	input  logic            uop_stall,
	output eslp_pkg::uop_t  uop
);
	import eslp_pkg::*;

	localparam logic [1:0] BOM_START = 2'd0;
	localparam logic [1:0] BOM_ONE   = 2'd1;
	localparam logic [1:0] BOM_TWO   = 2'd2;
	localparam logic [1:0] BOM_DONE  = 2'd3;

	logic [1:0] bom_q, bom_d;
	logic       cr_q, cr_d;
	uop_t       lst_q [3];
	uop_t       lst_d [3];
	logic [1:0] cnt_q, cnt_d;
	logic       push, take;
	logic       rep_ef, rep_bb, cr_c, main_c, main_le, eos;

	assign uop_valid  = (cnt_q != 2'd0);
	assign uop        = lst_q[0];
	assign push       = uop_valid && !uop_stall;
	assign item_stall = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && push));
	assign take       = item_valid && !item_stall;

	// classify the item
	always_comb begin
		rep_ef  = 1'b0;
		rep_bb  = 1'b0;
		cr_c    = 1'b0;
		main_c  = 1'b0;
		main_le = 1'b0;
		eos     = 1'b0;
		bom_d   = bom_q;
		cr_d    = cr_q;
		if (item.op == OP_BYTE) begin
			logic do_feed;
			do_feed = 1'b0;
			unique case (bom_q)
				BOM_START: begin
					if (item.byte_in == CH_BOM0) bom_d = BOM_ONE;
					else begin
						bom_d   = BOM_DONE;
						do_feed = 1'b1;
					end
				end
				BOM_ONE: begin
					if (item.byte_in == CH_BOM1) bom_d = BOM_TWO;
					else begin
						rep_ef  = 1'b1;
						bom_d   = BOM_DONE;
						do_feed = 1'b1;
					end
				end
				BOM_TWO: begin
					if (item.byte_in == CH_BOM2) bom_d = BOM_DONE;
					else begin
						rep_ef  = 1'b1;
						rep_bb  = 1'b1;
						bom_d   = BOM_DONE;
						do_feed = 1'b1;
					end
				end
				default: do_feed = 1'b1;
			endcase
			if (do_feed) begin
				if (cr_q && item.byte_in == CH_LF) begin
					cr_d    = 1'b0;
					main_le = 1'b1;
				end else begin
					cr_c = cr_q;
					if (item.byte_in == CH_CR) cr_d = 1'b1;
					else begin
						cr_d = 1'b0;
						if (item.byte_in == CH_LF) main_le = 1'b1;
						else main_c = 1'b1;
					end
				end
			end
		end else begin
			if (bom_q == BOM_ONE || bom_q == BOM_TWO) begin
				rep_ef = 1'b1;
				rep_bb = (bom_q == BOM_TWO);
				bom_d  = BOM_DONE;
			end
			// a held cr pairs with the implied lf and ends the line
			main_le = cr_q;
			cr_d    = 1'b0;
			eos     = 1'b1;
		end
	end

	// build the operation list, oldest first
	always_comb begin
		uop_t       nl [3];
		logic [1:0] n;
		for (int i = 0; i < 3; i++) nl[i] = '{code: UOP_CONTENT, data: CH_NUL, last: 1'b0};
		n = 2'd0;
		if (rep_ef) begin
			nl[n] = '{code: UOP_CONTENT, data: CH_BOM0, last: 1'b0};
			n     = n + 2'd1;
		end
		if (rep_bb) begin
			nl[n] = '{code: UOP_CONTENT, data: CH_BOM1, last: 1'b0};
			n     = n + 2'd1;
		end
		if (cr_c) begin
			nl[n] = '{code: UOP_CONTENT, data: CH_CR, last: 1'b0};
			n     = n + 2'd1;
		end
		if (main_c) begin
			nl[n] = '{code: UOP_CONTENT, data: item.byte_in, last: 1'b0};
			n     = n + 2'd1;
		end
		if (main_le) begin
			nl[n] = '{code: UOP_LINE_END, data: CH_LF, last: 1'b0};
			n     = n + 2'd1;
		end
		if (eos) begin
			nl[n] = '{code: UOP_EOS, data: CH_NUL, last: 1'b0};
			n     = n + 2'd1;
		end
		if (n != 2'd0) nl[n - 2'd1].last = 1'b1;

		lst_d = lst_q;
		cnt_d = cnt_q;
		if (push) begin
			lst_d[0] = lst_q[1];
			lst_d[1] = lst_q[2];
			cnt_d    = cnt_q - 2'd1;
		end
		if (take) begin
			lst_d = nl;
			cnt_d = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bom_q <= BOM_START;
			cr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (take) begin
				bom_q <= bom_d;
				cr_q  <= cr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		lst_q <= lst_d;
	end

endmodule

[rtl/core/eslp_queue.sv]
// ---------------------------------------------------------------------------
// eslp_queue
// small fifo of operations between front and back
// ---------------------------------------------------------------------------
module eslp_queue #(
	parameter int DEPTH = eslp_pkg::QDEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  eslp_pkg::uop_t wr_data,
	output logic           rd_valid,
	input  logic           rd_stall,
	output eslp_pkg::uop_t rd_data
);
	import eslp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	uop_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr, rd;

	assign wr_stall = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && !wr_stall;
	assign rd       = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (wr && !rd) cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

[rtl/core/eslp_back.sv]
// ---------------------------------------------------------------------------
// eslp_back
// line and field parser, type and id stores, dispatch sequencer, result stage
// ---------------------------------------------------------------------------
module eslp_back #(
	parameter int TYPE_MAX = eslp_pkg::TYPE_MAX_DEF,
	parameter int ID_MAX   = eslp_pkg::ID_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              uop_valid,
	output logic              uop_stall,
	input  eslp_pkg::uop_t    uop,
	output logic              res_valid,
	input  logic              res_stall,
	output eslp_pkg::result_t res
);
	import eslp_pkg::*;

	localparam int TLW = $clog2(TYPE_MAX + 1);
	localparam int TIW = $clog2(TYPE_MAX);
	localparam int ILW = $clog2(ID_MAX + 1);
	localparam int IIW = (ID_MAX > 1) ? $clog2(ID_MAX) : 1;
	localparam int CW  = (TLW > ILW) ? TLW : ILW;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_NAME  = 3'd1;
	localparam logic [2:0] PH_AFTER = 3'd2;
	localparam logic [2:0] PH_VAL   = 3'd3;
	localparam logic [2:0] PH_IGN   = 3'd4;

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_TYPE = 3'd1;
	localparam logic [2:0] ST_ID   = 3'd2;
	localparam logic [2:0] ST_END  = 3'd3;
	localparam logic [2:0] ST_DISC = 3'd4;

	logic [2:0]     st_q, st_d;
	logic [2:0]     ph_q, ph_d;
	logic [3:0]     nm_q, nm_d;
	logic [2:0]     nc_q, nc_d;
	logic           lhb_q, lhb_d;
	logic           dp_q, dp_d;
	logic [TLW-1:0] tlen_q, tlen_d;
	logic [ILW-1:0] ilen_q, ilen_d;
	logic [ILW-1:0] slen_q, slen_d;
	logic           snul_q, snul_d;
	logic           sover_q, sover_d;
	logic [1:0]     ovf_q, ovf_d;
	logic [CW-1:0]  idx_q, idx_d;
	logic           clast_q, clast_d;
	logic [7:0]     type_q [TYPE_MAX];
	logic [7:0]     id_q [ID_MAX];
	logic [7:0]     shd_q [ID_MAX];

	logic           type_we, type_msg, shd_we, id_copy;
	logic [7:0]     wbyte;
	logic           go, act;
	logic           r_v, flush;
	result_t        r;
	logic [3:0]     m_res;

	result_t        pend_q;
	logic           pend_v_q, pend_fin_q;
	logic           out_v_q, out_free, move;
	result_t        out_q;

	assign out_free  = !out_v_q || !res_stall;
	assign go        = !pend_v_q || out_free;
	assign uop_stall = !((st_q == ST_RUN) && go);
	assign act       = (st_q == ST_RUN) ? (uop_valid && go) : go;
	assign m_res     = name_resolve(nm_q, nc_q);
	assign res_valid = out_v_q;
	assign res       = out_q;

	always_comb begin
		logic       do_val, do_res, do_le;
		logic [7:0] c;
		do_val   = 1'b0;
		do_res   = 1'b0;
		do_le    = 1'b0;
		c        = uop.data;
		st_d     = st_q;
		ph_d     = ph_q;
		nm_d     = nm_q;
		nc_d     = nc_q;
		lhb_d    = lhb_q;
		dp_d     = dp_q;
		tlen_d   = tlen_q;
		ilen_d   = ilen_q;
		slen_d   = slen_q;
		snul_d   = snul_q;
		sover_d  = sover_q;
		ovf_d    = ovf_q;
		idx_d    = idx_q;
		clast_d  = clast_q;
		type_we  = 1'b0;
		type_msg = 1'b0;
		shd_we   = 1'b0;
		id_copy  = 1'b0;
		wbyte    = c;
		r_v      = 1'b0;
		r        = '{kind: K_DATA, byte_out: CH_NUL, overflow: 1'b0, last: 1'b0};
		flush    = 1'b0;

		if (act) begin
			unique case (st_q)
				ST_RUN: begin
					flush = uop.last;
					unique case (uop.code)
						UOP_CONTENT: begin
							unique case (ph_q)
								PH_START: begin
									lhb_d = 1'b1;
									if (c == CH_COLON) ph_d = PH_IGN;
									else begin
										ph_d = PH_NAME;
										nm_d = name_step(F_ALL, 3'd0, c);
										nc_d = 3'd1;
									end
								end
								PH_NAME: begin
									if (c == CH_COLON) begin
										do_res = 1'b1;
										ph_d   = PH_AFTER;
									end else begin
										nm_d = name_step(nm_q, nc_q, c);
										if (nc_q != 3'd7) nc_d = nc_q + 3'd1;
									end
								end
								PH_AFTER: begin
									ph_d   = PH_VAL;
									do_val = (c != CH_SPACE);
								end
								PH_VAL: do_val = 1'b1;
								default: ;
							endcase
						end
						UOP_LINE_END: begin
							if (lhb_q) do_le = 1'b1;
							else begin
								ph_d  = PH_START;
								nm_d  = F_ALL;
								nc_d  = 3'd0;
								if (dp_q) begin
									flush   = 1'b0;
									clast_d = uop.last;
									st_d    = ST_TYPE;
									idx_d   = '0;
								end else begin
									type_msg = 1'b1;
									ovf_d[0] = 1'b0;
								end
							end
						end
						default: begin
							do_le = lhb_q;
							if (dp_q) begin
								flush   = 1'b0;
								clast_d = uop.last;
								st_d    = ST_DISC;
							end
						end
					endcase
				end
				ST_TYPE: begin
					if (idx_q < CW'(tlen_q)) begin
						r_v   = 1'b1;
						r     = '{kind: K_TYPE, byte_out: type_q[idx_q[TIW-1:0]],
							overflow: 1'b0, last: 1'b0};
						idx_d = idx_q + CW'(1);
					end else begin
						st_d  = ST_ID;
						idx_d = '0;
					end
				end
				ST_ID: begin
					if (idx_q < CW'(ilen_q)) begin
						r_v   = 1'b1;
						r     = '{kind: K_ID, byte_out: id_q[idx_q[IIW-1:0]],
							overflow: 1'b0, last: 1'b0};
						idx_d = idx_q + CW'(1);
					end else st_d = ST_END;
				end
				ST_END: begin
					r_v      = 1'b1;
					r        = '{kind: K_END, byte_out: CH_NUL, overflow: |ovf_q, last: 1'b0};
					dp_d     = 1'b0;
					type_msg = 1'b1;
					ovf_d[0] = 1'b0;
					st_d     = ST_RUN;
					flush    = clast_q;
				end
				default: begin
					r_v   = 1'b1;
					r     = '{kind: K_DISCARD, byte_out: CH_NUL, overflow: 1'b0, last: 1'b0};
					dp_d  = 1'b0;
					st_d  = ST_RUN;
					flush = clast_q;
				end
			endcase
		end

		// line end inside a line: resolve a bare name, commit a clean id
		if (do_le) begin
			if (ph_q == PH_NAME) do_res = 1'b1;
			if ((ph_q == PH_NAME || ph_q == PH_AFTER || ph_q == PH_VAL) &&
					(((ph_q == PH_NAME) ? m_res : nm_q) == F_ID) &&
					((ph_q == PH_NAME) || !snul_q)) begin
				id_copy  = (ph_q != PH_NAME);
				ilen_d   = (ph_q == PH_NAME) ? '0 : slen_q;
				ovf_d[1] = (ph_q == PH_NAME) ? 1'b0 : sover_q;
			end
			ph_d  = PH_START;
			lhb_d = 1'b0;
			nc_d  = 3'd0;
		end

		if (do_res) begin
			priority if (m_res == F_EVENT) begin
				tlen_d   = '0;
				ovf_d[0] = 1'b0;
			end else if (m_res == F_DATA) begin
				if (dp_q) begin
					r_v = 1'b1;
					r   = '{kind: K_DATA, byte_out: CH_LF, overflow: 1'b0, last: 1'b0};
				end
			end else if (m_res == F_ID) begin
				slen_d  = '0;
				snul_d  = 1'b0;
				sover_d = 1'b0;
			end
			nm_d = m_res;
		end
		if (do_le) nm_d = F_ALL;

		if (do_val) begin
			priority if (nm_q == F_EVENT) begin
				if (tlen_q < TLW'(TYPE_MAX)) begin
					type_we = 1'b1;
					tlen_d  = tlen_q + TLW'(1);
				end else ovf_d[0] = 1'b1;
			end else if (nm_q == F_DATA) begin
				r_v  = 1'b1;
				r    = '{kind: K_DATA, byte_out: c, overflow: 1'b0, last: 1'b0};
				dp_d = 1'b1;
			end else if (nm_q == F_ID) begin
				if (c == CH_NUL) snul_d = 1'b1;
				if (slen_q < ILW'(ID_MAX)) begin
					shd_we = 1'b1;
					slen_d = slen_q + ILW'(1);
				end else sover_d = 1'b1;
			end
		end
	end

	assign move = pend_v_q && out_free && (pend_fin_q || r_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_RUN;
			ph_q       <= PH_START;
			nm_q       <= F_ALL;
			nc_q       <= 3'd0;
			lhb_q      <= 1'b0;
			dp_q       <= 1'b0;
			tlen_q     <= TLW'(MSG_LEN);
			ilen_q     <= '0;
			slen_q     <= '0;
			snul_q     <= 1'b0;
			sover_q    <= 1'b0;
			ovf_q      <= 2'b00;
			idx_q      <= '0;
			clast_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < TYPE_MAX; i++)
				type_q[i] <= (i < MSG_LEN) ? msg_char(3'(i)) : CH_NUL;
		end else begin
			st_q    <= st_d;
			ph_q    <= ph_d;
			nm_q    <= nm_d;
			nc_q    <= nc_d;
			lhb_q   <= lhb_d;
			dp_q    <= dp_d;
			tlen_q  <= type_msg ? TLW'(MSG_LEN) : tlen_d;
			ilen_q  <= ilen_d;
			slen_q  <= slen_d;
			snul_q  <= snul_d;
			sover_q <= sover_d;
			ovf_q   <= ovf_d;
			idx_q   <= idx_d;
			clast_q <= clast_d;
			if (type_msg) begin
				for (int i = 0; i < MSG_LEN; i++) type_q[i] <= msg_char(3'(i));
			end else if (type_we) type_q[tlen_q[TIW-1:0]] <= wbyte;

			// result holding slot: last is known once the next result or item end shows
			if (r_v) begin
				pend_v_q   <= 1'b1;
				pend_fin_q <= flush;
			end else if (move) begin
				pend_v_q   <= 1'b0;
				pend_fin_q <= 1'b0;
			end else if (flush && pend_v_q) pend_fin_q <= 1'b1;

			if (move) out_v_q <= 1'b1;
			else if (out_v_q && !res_stall) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (r_v) pend_q <= r;
		if (move) out_q <= '{kind: pend_q.kind, byte_out: pend_q.byte_out,
			overflow: pend_q.overflow, last: pend_fin_q};
		if (shd_we) shd_q[slen_q[IIW-1:0]] <= wbyte;
		if (id_copy) id_q <= shd_q;
	end

	a_fin_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_fin_q |-> pend_v_q) else $error("final flag without held result");
	a_type_len: assert property (@(posedge clk) disable iff (!arst_n)
		tlen_q <= TLW'(TYPE_MAX)) else $error("type length beyond store");
	a_shadow_len: assert property (@(posedge clk) disable iff (!arst_n)
		slen_q <= ILW'(ID_MAX)) else $error("shadow length beyond store");
	a_dispatch_data: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_TYPE || st_q == ST_ID || st_q == ST_END || st_q == ST_DISC) |-> dp_q)
		else $error("dispatch sequence without pending data");
	a_move_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(r_v && pend_v_q) |-> move) else $error("held result overwritten");

endmodule

[rtl/core/event_stream_line_parser_unit.sv]
// ---------------------------------------------------------------------------
// event_stream_line_parser_unit
// splits a byte stream into event-stream lines and fields, emits tagged bytes
// ---------------------------------------------------------------------------
// usage:
//  item channel (item_valid/item_stall/item): one transaction per stream byte
//    (op = byte) or one end-of-stream marker (op = end of stream)
//  result channel (res_valid/res_stall/res): data, type and id bytes, event
//    end and discard markers; last flags the final result of one input
//  path: the first result of an item passes the front stage, the queue, the
//    parser with its holding slot and the output register
//  throughput: the front expands each transaction into zero to three internal
//    operations and issues one per cycle while not stalled; plain bytes flow at
//    about one per cycle; on a blank line with data the dispatch sequencer in the
//    back end sends each stored type and id byte, then the end marker
//  reset: clears the parser to line start, type to message, empty id, and
//    rearms the byte-order-mark check; the id stores are left as they are
//  stall: a stalled result holds in the output register; the back end and the
//    queue then fill and item_stall rises, nothing is dropped
module event_stream_line_parser_unit #(
	parameter int TYPE_MAX = eslp_pkg::TYPE_MAX_DEF,
	parameter int ID_MAX   = eslp_pkg::ID_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  eslp_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_stall,
	output eslp_pkg::result_t res
);
	import eslp_pkg::*;

	// front to queue
	logic f_valid, f_stall;
	uop_t f_uop;
	// queue to back
	logic q_valid, q_stall;
	uop_t q_uop;

	// front: bom check, cr pairing, item to operation expansion
	eslp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.uop_valid  (f_valid),
		.uop_stall  (f_stall),
		.uop        (f_uop)
	);

	// decoupling queue so a dispatch burst does not stop the front at once
	eslp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_data  (f_uop),
		.rd_valid (q_valid),
		.rd_stall (q_stall),
		.rd_data  (q_uop)
	);

	// back: field parser, stores and result stage
	eslp_back #(
		.TYPE_MAX (TYPE_MAX),
		.ID_MAX   (ID_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop_valid (q_valid),
		.uop_stall (q_stall),
		.uop       (q_uop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[bench/event_stream_line_parser_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// event_stream_line_parser_unit_tb
// drives event-stream bytes and end-of-stream markers into the line parser,
// predicts the tagged result bytes and markers, and checks every result
// ---------------------------------------------------------------------------
module event_stream_line_parser_unit_tb;
	import eslp_pkg::*;

	localparam int TMAX = TYPE_MAX_DEF;
	localparam int IMAX = ID_MAX_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    res_valid;
	logic    res_stall;
	result_t res;

	event_stream_line_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// ---- parser state mirror ----
	logic [1:0] bom_cnt;
	logic [2:0] phase;
	logic [3:0] cand;
	logic [2:0] name_len;
	logic       cr_pend;
	logic       line_busy;
	logic       data_pend;
	logic [7:0] ev_type [TMAX];
	int         ev_type_len;
	logic [7:0] ev_id [IMAX];
	int         ev_id_len;
	logic [7:0] id_work [IMAX];
	int         id_work_len;
	logic       id_work_nul;
	logic       id_work_over;
	logic [1:0] trunc_flags;

	item_t   pending_items [$];
	result_t expected_results [$];
	int      step_start;

	int  n_sent = 0;
	int  n_recv = 0;
	int  n_dispatch = 0;
	int  n_discard = 0;
	bit  failed = 1'b0;
	int  idle_pct, stall_pct;
	bit  hold_sender;
	int  quiet_cycles = 0;

	function automatic logic [7:0] field_char(int k, int i);
		string s;
		case (k)
			0: s = "event";
			1: s = "data";
			2: s = "id";
			default: s = "retry";
		endcase
		return (i < s.len()) ? s[i] : CH_NUL;
	endfunction

	function automatic int field_len(int k);
		case (k)
			0: return 5;
			1: return 4;
			2: return 2;
			default: return 5;
		endcase
	endfunction

	function automatic void push_result(logic [2:0] k, logic [7:0] b, logic ov);
		result_t r;
		r.kind = k;
		r.byte_out = b;
		r.overflow = ov;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void reset_type();
		string m;
		m = "message";
		for (int i = 0; i < 7; i++)
			ev_type[i] = m[i];
		ev_type_len = 7;
		trunc_flags[0] = 1'b0;
	endfunction

	// blank line: emit stored type, id and end marker if data is waiting
	function automatic void fire_event();
		if (data_pend) begin
			for (int i = 0; i < ev_type_len; i++)
				push_result(K_TYPE, ev_type[i], 1'b0);
			for (int i = 0; i < ev_id_len; i++)
				push_result(K_ID, ev_id[i], 1'b0);
			push_result(K_END, 8'h00, trunc_flags != 2'b00);
			data_pend = 1'b0;
			n_dispatch++;
		end
		reset_type();
	endfunction

	function automatic void settle_field();
		logic [3:0] m;
		m = 4'b0000;
		for (int k = 0; k < 4; k++)
			if (cand[k] && field_len(k) == name_len)
				m = 4'(1 << k);
		cand = m;
		if (m == F_EVENT) begin
			ev_type_len = 0;
			trunc_flags[0] = 1'b0;
		end else if (m == F_DATA) begin
			if (data_pend)
				push_result(K_DATA, CH_LF, 1'b0);
		end else if (m == F_ID) begin
			id_work_len = 0;
			id_work_nul = 1'b0;
			id_work_over = 1'b0;
		end
	endfunction

	function automatic void take_value(logic [7:0] c);
		if (cand == F_EVENT) begin
			if (ev_type_len < TMAX) ev_type[ev_type_len++] = c;
			else trunc_flags[0] = 1'b1;
		end else if (cand == F_DATA) begin
			push_result(K_DATA, c, 1'b0);
			data_pend = 1'b1;
		end else if (cand == F_ID) begin
			if (c == CH_NUL) id_work_nul = 1'b1;
			if (id_work_len < IMAX) id_work[id_work_len++] = c;
			else id_work_over = 1'b1;
		end
	endfunction

	function automatic void take_name(logic [7:0] c);
		for (int k = 0; k < 4; k++)
			if (cand[k] && (name_len >= field_len(k) || field_char(k, name_len) != c))
				cand[k] = 1'b0;
		if (name_len < 7) name_len++;
	endfunction

	function automatic void line_char(logic [7:0] c);
		case (phase)
			3'd0: begin
				line_busy = 1'b1;
				if (c == CH_COLON) phase = 3'd4;
				else begin
					phase = 3'd1;
					cand = F_ALL;
					name_len = 0;
					take_name(c);
				end
			end
			3'd1: begin
				if (c == CH_COLON) begin
					settle_field();
					phase = 3'd2;
				end else take_name(c);
			end
			3'd2: begin
				phase = 3'd3;
				if (c != CH_SPACE) take_value(c);
			end
			3'd3: take_value(c);
			default: ;
		endcase
	endfunction

	function automatic void close_line();
		if (!line_busy) fire_event();
		else begin
			if (phase == 3'd1) settle_field();
			if (phase >= 3'd1 && phase <= 3'd3 && cand == F_ID && !id_work_nul) begin
				for (int i = 0; i < id_work_len; i++)
					ev_id[i] = id_work[i];
				ev_id_len = id_work_len;
				trunc_flags[1] = id_work_over;
			end
		end
		phase = 3'd0;
		line_busy = 1'b0;
		cand = F_ALL;
		name_len = 0;
	endfunction

	// line splitting with a held carriage return
	function automatic void split_byte(logic [7:0] c);
		if (cr_pend) begin
			cr_pend = 1'b0;
			if (c == CH_LF) begin
				close_line();
				return;
			end
			line_char(CH_CR);
		end
		if (c == CH_CR) cr_pend = 1'b1;
		else if (c == CH_LF) close_line();
		else line_char(c);
	endfunction

	function automatic void flush_bom();
		logic [1:0] held;
		if (bom_cnt == 2'd1 || bom_cnt == 2'd2) begin
			held = bom_cnt;
			bom_cnt = 2'd3;
			split_byte(CH_BOM0);
			if (held == 2'd2) split_byte(CH_BOM1);
		end
	endfunction

	function automatic void parser_clear();
		bom_cnt = 2'd0;
		phase = 3'd0;
		cand = F_ALL;
		name_len = 0;
		cr_pend = 1'b0;
		line_busy = 1'b0;
		data_pend = 1'b0;
		reset_type();
		ev_id_len = 0;
		id_work_len = 0;
		id_work_nul = 1'b0;
		id_work_over = 1'b0;
		trunc_flags = 2'b00;
	endfunction

	// expected results of one accepted transaction, last bit on the final one
	function automatic void predict_item(item_t it);
		step_start = expected_results.size();
		if (it.op == OP_BYTE) begin
			case (bom_cnt)
				2'd0: begin
					if (it.byte_in == CH_BOM0) bom_cnt = 2'd1;
					else begin
						bom_cnt = 2'd3;
						split_byte(it.byte_in);
					end
				end
				2'd1: begin
					if (it.byte_in == CH_BOM1) bom_cnt = 2'd2;
					else begin
						flush_bom();
						split_byte(it.byte_in);
					end
				end
				2'd2: begin
					if (it.byte_in == CH_BOM2) bom_cnt = 2'd3;
					else begin
						flush_bom();
						split_byte(it.byte_in);
					end
				end
				default: split_byte(it.byte_in);
			endcase
		end else begin
			flush_bom();
			if (line_busy || cr_pend) split_byte(CH_LF);
			if (data_pend) begin
				push_result(K_DISCARD, 8'h00, 1'b0);
				data_pend = 1'b0;
				n_discard++;
			end
		end
		if (expected_results.size() > step_start)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	// ---- stimulus helpers ----
	task automatic add_byte(logic [7:0] b);
		item_t it;
		it.op = OP_BYTE;
		it.byte_in = b;
		pending_items.push_back(it);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_eos(logic [7:0] junk);
		item_t it;
		it.op = OP_EOS;
		it.byte_in = junk;
		pending_items.push_back(it);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// one random line, mostly well-formed fields
	task automatic add_random_line();
		int sel, n;
		sel = $urandom_range(0, 99);
		if (sel < 35) add_text("data");
		else if (sel < 50) add_text("event");
		else if (sel < 65) add_text("id");
		else if (sel < 70) add_text("retry");
		else if (sel < 77) add_byte(CH_COLON);
		else if (sel < 85) add_text("dat");
		else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) add_byte(rand_byte());
		end
		if ($urandom_range(0, 9) < 8) add_byte(CH_COLON);
		if ($urandom_range(0, 1)) add_byte(CH_SPACE);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) add_byte(CH_NUL);
			else if ($urandom_range(0, 19) == 0) add_byte(CH_CR);
			else if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h61, 8'h7a)));
			else add_byte(rand_byte());
		end
		if ($urandom_range(0, 3) == 0) add_byte(CH_CR);
		add_byte(CH_LF);
		if ($urandom_range(0, 2) == 0) add_byte(CH_LF);
	endtask

	// ---- clock, reset ----
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---- driver: presents queued items with random idle cycles ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			parser_clear();
		end else begin
			if (item_valid && !item_stall) begin
				predict_item(item);
				n_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 && !hold_sender &&
						$urandom_range(0, 99) >= idle_pct) begin
					item_valid <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor: checks each accepted result against the oldest expectation ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				n_recv++;
				if (expected_results.size() == 0) begin
					$error("unexpected result kind=%0d byte=%02h", res.kind, res.byte_out);
					failed = 1'b1;
				end else begin
					result_t e;
					e = expected_results.pop_front();
					if (res.kind !== e.kind) begin
						$error("kind mismatch: expected %0d actual %0d", e.kind, res.kind);
						failed = 1'b1;
					end
					if (res.byte_out !== e.byte_out) begin
						$error("byte_out mismatch: expected %02h actual %02h",
							e.byte_out, res.byte_out);
						failed = 1'b1;
					end
					if (res.overflow !== e.overflow) begin
						$error("overflow mismatch: expected %0b actual %0b",
							e.overflow, res.overflow);
						failed = 1'b1;
					end
					if (res.last !== e.last) begin
						$error("last mismatch: expected %0b actual %0b", e.last, res.last);
						failed = 1'b1;
					end
				end
			end
			res_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ---- watchdog: cycles without any accepted transaction ----
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired: sent %0d, received %0d, %0d outstanding",
				n_sent, n_recv, expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	// ---- test sequence ----
	initial begin
		int phase_idx;
		idle_pct = 0; stall_pct = 0; hold_sender = 1'b0;
		@(posedge arst_n);

		// directed: partial bom replayed, then a data event with a long type
		add_byte(CH_BOM0); add_byte(CH_BOM1); add_byte(8'h41); add_byte(CH_LF);
		add_text("data: ok\r\n");
		add_text("event:abcdefghijklmnopq\n");
		add_text("id:\n:c\n\n");
		drain();

		// sender is held once every expected result has come
		hold_sender = 1'b1;
		repeat (10) @(posedge clk);
		hold_sender = 1'b0;

		// directed: nul id rejected, lone cr, empty data, eos with pending data
		add_text("id:x\n"); add_byte(8'h69); add_byte(8'h64); add_byte(CH_COLON);
		add_byte(CH_NUL); add_byte(CH_LF);
		add_text("data\ndata:a\rb\n"); add_byte(8'hFF); add_byte(8'h80);
		add_eos(8'hFF);
		add_text("\n"); add_eos(8'h00);
		// held cr on a blank line at end of stream dispatches the event
		add_text("data:z\n\r"); add_eos(8'h00);
		drain();

		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			idle_pct  = (phase_idx == 1 || phase_idx == 3) ? ((phase_idx == 3) ? 26 : 62) : 0;
			stall_pct = (phase_idx == 2 || phase_idx == 3) ? ((phase_idx == 3) ? 26 : 62) : 0;
			while (pending_items.size() < 90 + 90 * phase_idx - 0) begin
				if ($urandom_range(0, 29) == 0) add_eos(rand_byte());
				else if ($urandom_range(0, 39) == 0) add_byte(rand_byte());
				else add_random_line();
				if (pending_items.size() >= 90) break;
			end
			drain();
		end
		idle_pct = 0;
		stall_pct = 0;
		repeat (50) @(posedge clk);

		$display("covered %0d transactions, %0d results, %0d events dispatched, %0d discards",
			n_sent, n_recv, n_dispatch, n_discard);
		$display("including bom replay, nul ids, truncation, lone cr and idle/stall phases");
		if (!failed && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[event_stream_line_parser_unit.f]
rtl/core/eslp_pkg.sv
rtl/core/eslp_front.sv
rtl/core/eslp_queue.sv
rtl/core/eslp_back.sv
rtl/core/event_stream_line_parser_unit.sv
bench/event_stream_line_parser_unit_tb.sv
